[design/link_failure_recovery_tracker_defines.svh]
// ----------------------------------------------------------------------------
// Link failure recovery tracker - assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef LINK_FAILURE_RECOVERY_TRACKER_DEFINES_SVH
`define LINK_FAILURE_RECOVERY_TRACKER_DEFINES_SVH

// check a property outside reset
`define LFRT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every edge, reset included
`define LFRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/lfrt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrt_pkg
// Types, codes and widths shared by the link failure recovery tracker.
// ----------------------------------------------------------------------------
package lfrt_pkg;

  localparam int MAX_QUEUES_DEF = 16;
  localparam int GEN_BITS_DEF   = 32;

  localparam int REQ_W       = 3;
  localparam int IDX_W       = 8;
  localparam int WORD_W      = 32;
  localparam int BYTES_W     = 48;
  localparam int QCNT_W      = 5;
  localparam int CMP_W       = 9;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 120;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (1 + 2 + BYTES_W + WORD_W + WORD_W);

  typedef enum logic [REQ_W-1:0] {
    REQ_ACTIVATE = 3'd0,
    REQ_CLOSE    = 3'd1,
    REQ_FAIL     = 3'd2,
    REQ_CLEANUP  = 3'd3,
    REQ_POLL     = 3'd4,
    REQ_ADD      = 3'd5,
    REQ_REMOVE   = 3'd6,
    REQ_TICK     = 3'd7
  } req_type_t;

  typedef enum logic [1:0] {
    MODE_UNINIT = 2'd0,
    MODE_ACTIVE = 2'd1,
    MODE_FAILED = 2'd2,
    MODE_CLOSED = 2'd3
  } mode_t;

  typedef enum logic {
    CFG_QUEUE_COUNT = 1'b0,
    CFG_COOLDOWN    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic rd;
    logic cnt_clr;
    logic cnt_inc;
    logic recover;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic scan_go;
    logic match;
    logic last;
  } stat_t;

endpackage

[design/lfrt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrt_ctrl
// Event sequencer: capture, execute, queue stamp scan and result transfer.
// ----------------------------------------------------------------------------
module lfrt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  lfrt_pkg::stat_t stat,
  output lfrt_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_READ = 5'b00100,
    S_CMP  = 5'b01000,
    S_HOLD = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;
  logic   slot_free;

  assign slot_free  = !out_vld_r || out_tready;
  assign out_tvalid = out_vld_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.scan_go) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_READ;
        end else if (slot_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (stat.match && !stat.last) begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_READ;
        end else begin
          cmd.recover = stat.match;
          if (slot_free) begin
            cmd.load  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

[design/lfrt_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrt_dpath
// Link state, counters, queue stamp memory and result register.
// ----------------------------------------------------------------------------
module lfrt_dpath #(
  parameter int MAX_QUEUES = lfrt_pkg::MAX_QUEUES_DEF,
  parameter int GEN_BITS   = lfrt_pkg::GEN_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lfrt_pkg::cmd_t                     cmd,
  input  logic [lfrt_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [lfrt_pkg::WORD_W-1:0]        cfg_data,
  output lfrt_pkg::stat_t                    stat,
  output logic [lfrt_pkg::OUT_TDATA_W-1:0]   out_data
);

  localparam int AW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;

  // captured event
  lfrt_pkg::req_type_t               req_r;
  logic [lfrt_pkg::IDX_W-1:0]        idx_r;
  logic [lfrt_pkg::WORD_W-1:0]       bc_r;

  // configuration
  logic [lfrt_pkg::QCNT_W-1:0]       qcnt_r;
  logic [lfrt_pkg::WORD_W-1:0]       cool_r;

  // link state
  lfrt_pkg::mode_t                   mode_r, mode_nxt;
  logic                              clean_r, clean_nxt;
  logic [GEN_BITS-1:0]               gen_r, gen_nxt, gen_inc;
  logic [lfrt_pkg::BYTES_W-1:0]      bytes_r, bytes_nxt;
  logic [lfrt_pkg::WORD_W-1:0]       reqs_r, reqs_nxt;
  logic [lfrt_pkg::WORD_W-1:0]       recov_r, recov_nxt;
  logic [lfrt_pkg::WORD_W-1:0]       ticks_r, ticks_nxt;
  logic                              seen_r, seen_nxt;
  logic                              res_r, res_nxt;
  logic                              vld_clr;

  // queue stamps
  logic [GEN_BITS-1:0]               stamp_mem [MAX_QUEUES];
  logic [MAX_QUEUES-1:0]             qvld_r;
  logic [GEN_BITS-1:0]               rd_gen_r;
  logic                              rd_vld_r;
  logic [AW-1:0]                     cnt_r;

  logic [lfrt_pkg::CMP_W-1:0]        used_q;
  logic [lfrt_pkg::BYTES_W:0]        bsum;
  logic [lfrt_pkg::BYTES_W-1:0]      bc_ext;
  logic                              poll_ok;
  logic [lfrt_pkg::OUT_PAD_W-1:0]    pad;

  assign pad     = '0;
  assign bc_ext  = lfrt_pkg::BYTES_W'(bc_r);
  assign bsum    = {1'b0, bytes_r} + {1'b0, bc_ext};
  assign gen_inc = gen_r + GEN_BITS'(1);

  assign used_q = (lfrt_pkg::CMP_W'(qcnt_r) > lfrt_pkg::CMP_W'(MAX_QUEUES)) ?
                  lfrt_pkg::CMP_W'(MAX_QUEUES) : lfrt_pkg::CMP_W'(qcnt_r);

  assign poll_ok = (req_r == lfrt_pkg::REQ_POLL) && (mode_r == lfrt_pkg::MODE_FAILED) &&
                   clean_r && (lfrt_pkg::CMP_W'(idx_r) < used_q);

  assign stat.scan_go = poll_ok && (reqs_r == '0) && seen_r && (ticks_r >= cool_r);
  assign stat.match   = ((rd_vld_r ? rd_gen_r : '0) == gen_r);
  assign stat.last    = ((lfrt_pkg::CMP_W'(cnt_r) + lfrt_pkg::CMP_W'(1)) == used_q);

  always_comb begin
    mode_nxt  = mode_r;
    clean_nxt = clean_r;
    gen_nxt   = gen_r;
    bytes_nxt = bytes_r;
    reqs_nxt  = reqs_r;
    recov_nxt = recov_r;
    ticks_nxt = ticks_r;
    seen_nxt  = seen_r;
    res_nxt   = res_r;
    vld_clr   = 1'b0;
    if (cmd.exec) begin
      res_nxt = 1'b0;
      unique case (req_r)
        lfrt_pkg::REQ_ACTIVATE: begin
          if ((mode_r == lfrt_pkg::MODE_UNINIT) && (qcnt_r != '0)) begin
            vld_clr   = 1'b1;
            clean_nxt = 1'b0;
            mode_nxt  = lfrt_pkg::MODE_ACTIVE;
          end
        end
        lfrt_pkg::REQ_CLOSE: mode_nxt = lfrt_pkg::MODE_CLOSED;
        lfrt_pkg::REQ_FAIL: begin
          if ((mode_r == lfrt_pkg::MODE_ACTIVE) || (mode_r == lfrt_pkg::MODE_FAILED)) begin
            if (mode_r == lfrt_pkg::MODE_ACTIVE) begin
              mode_nxt  = lfrt_pkg::MODE_FAILED;
              clean_nxt = 1'b0;
              res_nxt   = 1'b1;
            end
            gen_nxt   = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
            ticks_nxt = '0;
            seen_nxt  = 1'b1;
          end
        end
        lfrt_pkg::REQ_CLEANUP: begin
          if (mode_r == lfrt_pkg::MODE_FAILED) begin
            clean_nxt = 1'b1;
          end
        end
        lfrt_pkg::REQ_POLL: res_nxt = 1'b0;
        lfrt_pkg::REQ_ADD: begin
          bytes_nxt = bsum[lfrt_pkg::BYTES_W] ? '1 : bsum[lfrt_pkg::BYTES_W-1:0];
          if (reqs_r != '1) begin
            reqs_nxt = reqs_r + lfrt_pkg::WORD_W'(1);
          end
        end
        lfrt_pkg::REQ_REMOVE: begin
          bytes_nxt = (bytes_r >= bc_ext) ? (bytes_r - bc_ext) : '0;
          if (reqs_r != '0) begin
            reqs_nxt = reqs_r - lfrt_pkg::WORD_W'(1);
          end
        end
        lfrt_pkg::REQ_TICK: begin
          if (ticks_r != '1) begin
            ticks_nxt = ticks_r + lfrt_pkg::WORD_W'(1);
          end
        end
        default: res_nxt = 1'b0;
      endcase
    end
    if (cmd.recover) begin
      mode_nxt  = lfrt_pkg::MODE_ACTIVE;
      clean_nxt = 1'b0;
      recov_nxt = recov_r + lfrt_pkg::WORD_W'(1);
      res_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= lfrt_pkg::req_type_t'(in_tdata[lfrt_pkg::REQ_W-1:0]);
      idx_r <= in_tdata[lfrt_pkg::REQ_W +: lfrt_pkg::IDX_W];
      bc_r  <= in_tdata[lfrt_pkg::REQ_W + lfrt_pkg::IDX_W +: lfrt_pkg::WORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r <= lfrt_pkg::QCNT_W'(1);
      cool_r <= '0;
    end else if (cfg_we) begin
      unique case (lfrt_pkg::cfg_reg_t'(cfg_index))
        lfrt_pkg::CFG_QUEUE_COUNT: qcnt_r <= cfg_data[lfrt_pkg::QCNT_W-1:0];
        lfrt_pkg::CFG_COOLDOWN:    cool_r <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= lfrt_pkg::MODE_UNINIT;
      clean_r <= 1'b0;
      gen_r   <= '0;
      bytes_r <= '0;
      reqs_r  <= '0;
      recov_r <= '0;
      ticks_r <= '0;
      seen_r  <= 1'b0;
      res_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      clean_r <= clean_nxt;
      gen_r   <= gen_nxt;
      bytes_r <= bytes_nxt;
      reqs_r  <= reqs_nxt;
      recov_r <= recov_nxt;
      ticks_r <= ticks_nxt;
      seen_r  <= seen_nxt;
      res_r   <= res_nxt;
    end
  end

  // stamp memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec && poll_ok) begin
      stamp_mem[idx_r[AW-1:0]] <= gen_r;
    end
    if (cmd.rd) begin
      rd_gen_r <= stamp_mem[cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qvld_r   <= '0;
      rd_vld_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (vld_clr) begin
        qvld_r <= '0;
      end else if (cmd.exec && poll_ok) begin
        qvld_r[idx_r[AW-1:0]] <= 1'b1;
      end
      if (cmd.rd) begin
        rd_vld_r <= qvld_r[cnt_r];
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data <= {pad, recov_nxt, reqs_nxt, bytes_nxt, mode_nxt, res_nxt};
    end
  end

endmodule

[design/link_failure_recovery_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_failure_recovery_tracker
// Link health and recovery tracker for a multi-queue transfer link.
// ----------------------------------------------------------------------------
// Input channel in_*: one event per transfer (type, queue index, byte count).
// Output channel out_*: exactly one result per event, in event order.
// Configuration channel cfg_*: always ready; write only while the block idles.
// Sequence: an input transfer is captured, the event is executed, and the result
// is then loaded in the output register. A poll success that passes the counter
// and cooldown checks also scans the stamp memory, one queue at a time (a read
// state, then a compare state) through the single registered read port of that
// memory, stopping at the first mismatch or at the last queue.
// Throughput: one event at a time; the next input transfer is taken in the
// cycle after the result is loaded, while that result still waits on out_*.
// Stall: with out_tready low the finished result holds in the output register;
// one further event is taken and processed, and its result waits until the
// register is free before another event is accepted.
// Reset (rst_n low, synchronous): link uninitialised, all counters and stamp
// valid flags cleared, queue count 1, cooldown 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module link_failure_recovery_tracker #(
  parameter int MAX_QUEUES = lfrt_pkg::MAX_QUEUES_DEF,
  parameter int GEN_BITS   = lfrt_pkg::GEN_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // req_type[2:0], queue_index[10:3], byte_count[42:11], zero fill
  input  logic [lfrt_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // event_result[0], life_state[2:1], inflight_total[50:3],
  // outstanding_requests[82:51], recoveries[114:83], zero fill
  output logic [lfrt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [lfrt_pkg::WORD_W-1:0]      cfg_data
);

  lfrt_pkg::cmd_t  cmd;
  lfrt_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  lfrt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lfrt_dpath #(
    .MAX_QUEUES (MAX_QUEUES),
    .GEN_BITS   (GEN_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .out_data  (out_tdata)
  );

endmodule

[design/lfrt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrt_checker
// Port-level checks on the link failure recovery tracker.
// ----------------------------------------------------------------------------
`include "link_failure_recovery_tracker_defines.svh"

module lfrt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lfrt_pkg::OUT_TDATA_W-1:0] out_tdata
);

  `LFRT_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result dropped or changed under stall")
  `LFRT_ASSERT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "event taken while previous one in progress")
  `LFRT_ASSERT(a_result_mode, clk, rst_n, out_tvalid && out_tdata[0] |-> (out_tdata[2:1] == lfrt_pkg::MODE_ACTIVE) || (out_tdata[2:1] == lfrt_pkg::MODE_FAILED), "event result flagged outside active or failed")
  `LFRT_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind link_failure_recovery_tracker lfrt_checker u_lfrt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the link failure recovery tracker. A short
// table of directed events (with a few results typed in by hand) is followed
// by randomised fail / cleanup / cooldown / poll recovery episodes with noise
// under several queue count and cooldown settings. After that come a short
// burst of full-size inflight additions and a closing phase.
// Every result is scored against its typed value or an in-bench tracker model,
// with random gaps on the event stream and random stalls on the result stream.
// ----------------------------------------------------------------------------
module testbench;
  import lfrt_pkg::*;

  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int PHASE_ITEMS  = 200;
  localparam int BIG_ADDS     = 16;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_MAX   = 10;
  localparam int IN_PAD_W     = IN_TDATA_W - REQ_W - IDX_W - WORD_W;
  localparam logic [BYTES_W-1:0] BYTES_TOP = '1;
  localparam logic [WORD_W-1:0]  WORD_TOP  = '1;

  typedef struct packed {
    logic                hit;
    mode_t               life;
    logic [BYTES_W-1:0]  inflight;
    logic [WORD_W-1:0]   outstanding;
    logic [WORD_W-1:0]   recoveries;
  } link_report_t;

  typedef struct {
    bit                  is_write;
    cfg_reg_t            reg_sel;
    logic [WORD_W-1:0]   reg_value;
    req_type_t           op;
    logic [IDX_W-1:0]    qidx;
    logic [WORD_W-1:0]   nbytes;
    bit                  typed;
    link_report_t        want;
  } stim_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // req_type[2:0], queue_index[10:3], byte_count[42:11], zero fill
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // event_result[0], life_state[2:1], inflight_total[50:3],
  // outstanding_requests[82:51], recoveries[114:83], zero fill
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index  = 1'b0;
  logic [WORD_W-1:0]      cfg_data   = '0;

  link_failure_recovery_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // tracker model state
  mode_t              lk_mode;
  bit                 lk_cleaned;
  bit                 lk_failed_once;
  bit                 lk_effect;
  logic [WORD_W-1:0]  lk_gen;
  logic [WORD_W-1:0]  lk_ticks;
  logic [WORD_W-1:0]  lk_reqs;
  logic [WORD_W-1:0]  lk_recov;
  logic [WORD_W-1:0]  lk_stamp [MAX_QUEUES_DEF];
  logic [BYTES_W-1:0] lk_bytes;
  logic [QCNT_W-1:0]  set_qcount;
  logic [WORD_W-1:0]  set_cooldown;

  link_report_t awaited_reports [$];
  stim_row_t    table_rows [$];

  bit          hold_tx = 1'b0;
  bit          hold_rx = 1'b0;
  int          faults = 0;
  int          events_sent = 0;
  int          effective_count = 0;
  int          results_seen = 0;
  int          reg_writes = 0;
  int          lk_downs = 0;
  int unsigned cycle_count = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("run stalled: %0d results still awaited after %0d cycles",
               awaited_reports.size(), cycle_count);
      $display("link_failure_recovery_tracker regression: fail");
      $finish;
    end
  end

  function automatic void log_fault(string what);
    if (faults < REPORT_MAX) $display("[%0t] %s", $time, what);
    faults++;
  endfunction

  function automatic void add_row(stim_row_t row);
    table_rows.insert(table_rows.size(), row);
  endfunction

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic int live_queues();
    return (set_qcount > MAX_QUEUES_DEF) ? MAX_QUEUES_DEF : int'(set_qcount);
  endfunction

  function automatic link_report_t track_link_event(req_type_t op, logic [IDX_W-1:0] qidx,
                                                   logic [WORD_W-1:0] nbytes);
    link_report_t       rep;
    logic [BYTES_W-1:0] wide;
    bit                 stamped;
    int                 i;
    rep.hit   = 1'b0;
    lk_effect = 1'b0;
    wide      = {{(BYTES_W - WORD_W){1'b0}}, nbytes};
    case (op)
      REQ_ACTIVATE: begin
        if (lk_mode == MODE_UNINIT && set_qcount != '0) begin
          foreach (lk_stamp[k]) lk_stamp[k] = '0;
          lk_cleaned = 1'b0;
          lk_mode    = MODE_ACTIVE;
          lk_effect  = 1'b1;
        end
      end
      REQ_CLOSE: begin
        lk_mode   = MODE_CLOSED;
        lk_effect = 1'b1;
      end
      REQ_FAIL: begin
        if (lk_mode == MODE_ACTIVE || lk_mode == MODE_FAILED) begin
          if (lk_mode == MODE_ACTIVE) begin
            lk_mode    = MODE_FAILED;
            lk_cleaned = 1'b0;
            rep.hit    = 1'b1;
            lk_downs++;
          end
          lk_gen = lk_gen + 1'b1;
          if (lk_gen == '0) lk_gen = 1;
          lk_ticks       = '0;
          lk_failed_once = 1'b1;
          lk_effect      = 1'b1;
        end
      end
      REQ_CLEANUP: begin
        if (lk_mode == MODE_FAILED) begin
          lk_cleaned = 1'b1;
          lk_effect  = 1'b1;
        end
      end
      REQ_POLL: begin
        if (lk_mode == MODE_FAILED && lk_cleaned && qidx < live_queues()) begin
          lk_stamp[qidx[3:0]] = lk_gen;
          lk_effect = 1'b1;
          stamped = 1'b1;
          for (i = 0; i < live_queues(); i++) begin
            if (lk_stamp[i] != lk_gen) stamped = 1'b0;
          end
          if (lk_reqs == '0 && lk_failed_once && lk_ticks >= set_cooldown && stamped) begin
            lk_mode    = MODE_ACTIVE;
            lk_cleaned = 1'b0;
            lk_recov   = lk_recov + 1'b1;
            rep.hit    = 1'b1;
          end
        end
      end
      REQ_ADD: begin
        if (BYTES_TOP - lk_bytes < wide) lk_bytes = BYTES_TOP;
        else lk_bytes = lk_bytes + wide;
        if (lk_reqs != WORD_TOP) lk_reqs = lk_reqs + 1'b1;
        lk_effect = 1'b1;
      end
      REQ_REMOVE: begin
        lk_bytes = (lk_bytes >= wide) ? lk_bytes - wide : '0;
        if (lk_reqs != '0) lk_reqs = lk_reqs - 1'b1;
        lk_effect = 1'b1;
      end
      default: begin
        if (lk_ticks != WORD_TOP) lk_ticks = lk_ticks + 1'b1;
        lk_effect = 1'b1;
      end
    endcase
    rep.life        = lk_mode;
    rep.inflight    = lk_bytes;
    rep.outstanding = lk_reqs;
    rep.recoveries  = lk_recov;
    return rep;
  endfunction

  function automatic stim_row_t ev_row(req_type_t op, logic [IDX_W-1:0] qidx,
                                       logic [WORD_W-1:0] nbytes);
    stim_row_t row;
    row.is_write  = 1'b0;
    row.reg_sel   = CFG_QUEUE_COUNT;
    row.reg_value = '0;
    row.op        = op;
    row.qidx      = qidx;
    row.nbytes    = nbytes;
    row.typed     = 1'b0;
    row.want      = '0;
    return row;
  endfunction

  function automatic stim_row_t fixed_row(req_type_t op, logic [IDX_W-1:0] qidx,
                                          logic [WORD_W-1:0] nbytes, logic hit, mode_t life,
                                          logic [BYTES_W-1:0] inflight,
                                          logic [WORD_W-1:0] reqs, logic [WORD_W-1:0] recov);
    stim_row_t row;
    row                  = ev_row(op, qidx, nbytes);
    row.typed            = 1'b1;
    row.want.hit         = hit;
    row.want.life        = life;
    row.want.inflight    = inflight;
    row.want.outstanding = reqs;
    row.want.recoveries  = recov;
    return row;
  endfunction

  function automatic stim_row_t reg_row(cfg_reg_t sel, logic [WORD_W-1:0] value);
    stim_row_t row;
    row           = ev_row(REQ_TICK, '0, '0);
    row.is_write  = 1'b1;
    row.reg_sel   = sel;
    row.reg_value = value;
    return row;
  endfunction

  task automatic send_event(req_type_t op, logic [IDX_W-1:0] qidx, logic [WORD_W-1:0] nbytes,
                            bit typed, link_report_t want);
    link_report_t predicted;
    int           gap;
    gap = hold_tx ? 0 : idle_span();
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{IN_PAD_W{1'b0}}, nbytes, qidx, op};
    do @(posedge clk); while (!in_tready);
    predicted = track_link_event(op, qidx, nbytes);
    awaited_reports.insert(awaited_reports.size(), typed ? want : predicted);
    events_sent++;
    if (lk_effect) effective_count++;
  endtask

  task automatic send_plain(req_type_t op, logic [IDX_W-1:0] qidx, logic [WORD_W-1:0] nbytes);
    send_event(op, qidx, nbytes, 1'b0, '0);
  endtask

  task automatic write_reg(cfg_reg_t sel, logic [WORD_W-1:0] value);
    in_tvalid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (sel == CFG_QUEUE_COUNT) set_qcount = value[QCNT_W-1:0];
    else set_cooldown = value;
    reg_writes++;
  endtask

  task automatic send_noise();
    req_type_t         op;
    logic [WORD_W-1:0] nbytes;
    int                r;
    do op = req_type_t'($urandom_range(0, 7)); while (op == REQ_CLOSE);
    r = $urandom_range(0, 9);
    if (r == 0) nbytes = '0;
    else if (r == 1) nbytes = WORD_TOP;
    else if (r < 6) nbytes = $urandom_range(0, 4096);
    else nbytes = $urandom();
    send_plain(op, IDX_W'($urandom()), nbytes);
  endtask

  // fail the link if needed, then walk it back towards active
  task automatic run_recovery_episode();
    int order [MAX_QUEUES_DEF];
    int n, j, k, tmp, wait_ticks;
    if (lk_mode == MODE_ACTIVE) begin
      repeat ($urandom_range(0, 3)) send_noise();
      send_plain(REQ_FAIL, IDX_W'($urandom()), $urandom());
    end
    if ($urandom_range(0, 3) == 0) send_plain(REQ_FAIL, IDX_W'($urandom()), $urandom());
    if ($urandom_range(0, 5) == 0) begin
      send_plain(REQ_POLL, IDX_W'($urandom_range(0, 15)), $urandom());
    end
    send_plain(REQ_CLEANUP, IDX_W'($urandom()), $urandom());
    if (set_cooldown > 8) wait_ticks = $urandom_range(0, 4);
    else wait_ticks = int'(set_cooldown) + $urandom_range(0, 2);
    if (wait_ticks > 0 && $urandom_range(0, 7) == 0) wait_ticks--;
    repeat (wait_ticks) send_plain(REQ_TICK, IDX_W'($urandom()), $urandom());
    while (lk_reqs != '0) send_plain(REQ_REMOVE, IDX_W'($urandom()), $urandom_range(0, 2000));
    n = live_queues();
    for (k = 0; k < n; k++) order[k] = k;
    for (k = n - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      send_plain(REQ_POLL, IDX_W'(order[k]), $urandom());
    end
  endtask

  initial begin : result_check
    link_report_t seen;
    link_report_t want;
    int           stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        seen.hit         = out_tdata[0];
        seen.life        = mode_t'(out_tdata[2:1]);
        seen.inflight    = out_tdata[50:3];
        seen.outstanding = out_tdata[82:51];
        seen.recoveries  = out_tdata[114:83];
        if (awaited_reports.size() == 0) begin
          log_fault($sformatf("result with nothing awaited: %h", out_tdata));
        end else begin
          want = awaited_reports.pop_front();
          if (seen.hit !== want.hit || seen.life !== want.life ||
              seen.inflight !== want.inflight || seen.outstanding !== want.outstanding ||
              seen.recoveries !== want.recoveries) begin
            log_fault($sformatf({"result %0d: exp hit=%0b life=%0d bytes=%0h reqs=%0h ",
                                 "rec=%0h, got hit=%0b life=%0d bytes=%0h reqs=%0h rec=%0h"},
                                results_seen, want.hit, want.life, want.inflight,
                                want.outstanding, want.recoveries, seen.hit, seen.life,
                                seen.inflight, seen.outstanding, seen.recoveries));
          end
          results_seen++;
        end
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if (!hold_rx && $urandom_range(0, 3) == 0) stall = idle_span();
      end
    end
  end

  initial begin : stimulus
    stim_row_t         row;
    logic [QCNT_W-1:0] qc;
    logic [WORD_W-1:0] cd;
    int                phase, phase_end, random_base, directed_count;

    lk_mode        = MODE_UNINIT;
    lk_cleaned     = 1'b0;
    lk_failed_once = 1'b0;
    lk_effect      = 1'b0;
    lk_gen         = '0;
    lk_ticks       = '0;
    lk_reqs        = '0;
    lk_recov       = '0;
    lk_bytes       = '0;
    foreach (lk_stamp[k]) lk_stamp[k] = '0;
    set_qcount     = 5'd1;
    set_cooldown   = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // refused activation and events before the link comes up
    add_row(reg_row(CFG_QUEUE_COUNT, 32'd0));
    add_row(fixed_row(REQ_ACTIVATE, 8'h00, 32'h0, 0, MODE_UNINIT, 0, 0, 0));
    add_row(fixed_row(REQ_FAIL, 8'hFF, WORD_TOP, 0, MODE_UNINIT, 0, 0, 0));
    add_row(fixed_row(REQ_CLEANUP, 8'h00, 32'h0, 0, MODE_UNINIT, 0, 0, 0));
    add_row(fixed_row(REQ_POLL, 8'h00, 32'h0, 0, MODE_UNINIT, 0, 0, 0));
    add_row(fixed_row(REQ_ADD, 8'hFF, WORD_TOP, 0, MODE_UNINIT, 48'hFFFF_FFFF, 1, 0));
    add_row(fixed_row(REQ_REMOVE, 8'h00, WORD_TOP, 0, MODE_UNINIT, 0, 0, 0));
    add_row(fixed_row(REQ_REMOVE, 8'h00, 32'h5, 0, MODE_UNINIT, 0, 0, 0));
    add_row(fixed_row(REQ_TICK, 8'hAA, 32'h5555_5555, 0, MODE_UNINIT, 0, 0, 0));
    // bring up with the queue count above its ceiling
    add_row(reg_row(CFG_QUEUE_COUNT, 32'd31));
    add_row(fixed_row(REQ_ACTIVATE, 8'h00, 32'h0, 0, MODE_ACTIVE, 0, 0, 0));
    add_row(fixed_row(REQ_ACTIVATE, 8'h00, 32'h0, 0, MODE_ACTIVE, 0, 0, 0));
    add_row(fixed_row(REQ_CLEANUP, 8'h00, 32'h0, 0, MODE_ACTIVE, 0, 0, 0));
    add_row(fixed_row(REQ_POLL, 8'h00, 32'h0, 0, MODE_ACTIVE, 0, 0, 0));
    add_row(fixed_row(REQ_FAIL, 8'h55, 32'hAAAA_AAAA, 1, MODE_FAILED, 0, 0, 0));
    add_row(fixed_row(REQ_FAIL, 8'h00, 32'h0, 0, MODE_FAILED, 0, 0, 0));
    add_row(fixed_row(REQ_POLL, 8'h00, 32'h0, 0, MODE_FAILED, 0, 0, 0));
    add_row(ev_row(REQ_CLEANUP, 8'h00, 32'h0));
    // two queues, upper data bits set, cooldown of two ticks
    add_row(reg_row(CFG_QUEUE_COUNT, 32'hFFFF_FFE2));
    add_row(reg_row(CFG_COOLDOWN, 32'd2));
    add_row(ev_row(REQ_POLL, 8'h00, 32'h0));
    add_row(ev_row(REQ_TICK, 8'h00, 32'h0));
    add_row(ev_row(REQ_TICK, 8'h00, 32'h0));
    add_row(ev_row(REQ_ADD, 8'h00, 32'd100));
    add_row(ev_row(REQ_POLL, 8'h01, 32'h0));
    add_row(ev_row(REQ_REMOVE, 8'h00, 32'd100));
    add_row(ev_row(REQ_POLL, 8'h02, 32'h0));
    add_row(ev_row(REQ_POLL, 8'hFF, 32'h0));
    add_row(ev_row(REQ_POLL, 8'h00, 32'h0));

    foreach (table_rows[r]) begin
      row = table_rows[r];
      if (row.is_write) write_reg(row.reg_sel, row.reg_value);
      else send_event(row.op, row.qidx, row.nbytes, row.typed, row.want);
    end
    directed_count = events_sent;

    random_base = effective_count;
    phase = 0;
    while (effective_count - random_base < RANDOM_ITEMS) begin
      case (phase % 8)
        0: begin qc = 5'd16; cd = 32'd0; end
        1: begin qc = 5'd1;  cd = 32'd1; end
        2: begin qc = 5'd17; cd = 32'd3; end
        3: begin qc = 5'd5;  cd = WORD_TOP; end
        4: begin qc = 5'd31; cd = 32'd2; end
        5: begin qc = 5'd0;  cd = 32'd0; end
        default: begin
          qc = $urandom_range(1, 16);
          cd = $urandom_range(0, 6);
        end
      endcase
      write_reg(CFG_QUEUE_COUNT, ($urandom() & ~32'h1F) | WORD_W'(qc));
      write_reg(CFG_COOLDOWN, cd);
      hold_tx   = ($urandom_range(0, 3) == 0);
      hold_rx   = ($urandom_range(0, 3) == 0);
      phase_end = effective_count + PHASE_ITEMS;
      while (effective_count < phase_end) run_recovery_episode();
      phase++;
    end

    // load the byte total with full-size transfers, then step back
    hold_tx = 1'b1;
    hold_rx = 1'b1;
    repeat (BIG_ADDS) send_plain(REQ_ADD, IDX_W'($urandom()), WORD_TOP);
    send_plain(REQ_REMOVE, IDX_W'($urandom()), 32'd1);
    hold_tx = 1'b0;
    hold_rx = 1'b0;

    // close is final: nothing but the counters moves after it
    send_plain(REQ_CLOSE, IDX_W'($urandom()), $urandom());
    send_plain(REQ_ACTIVATE, 8'h00, 32'h0);
    send_plain(REQ_FAIL, 8'h00, 32'h0);
    send_plain(REQ_CLEANUP, 8'h00, 32'h0);
    send_plain(REQ_POLL, 8'h00, 32'h0);
    send_plain(REQ_TICK, 8'h00, 32'h0);
    send_plain(REQ_REMOVE, 8'h00, WORD_TOP);
    send_plain(REQ_ADD, 8'h00, 32'h1234);
    send_plain(REQ_CLOSE, 8'h00, 32'h0);

    in_tvalid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d events (%0d directed, %0d full-size adds), %0d results checked",
             events_sent, directed_count, BIG_ADDS, results_seen);
    $display("%0d link failures, %0d recoveries, %0d register writes, %0d faults",
             lk_downs, lk_recov, reg_writes, faults);
    if (faults == 0) $display("link_failure_recovery_tracker regression: pass");
    else $display("link_failure_recovery_tracker regression: fail");
    $finish;
  end

endmodule
